>>> hw/rtl/fmsds_pkg.sv
// Package for the multi-server dispatch block: field widths and the
// packed item types of both channels. No dependencies.
package fmsds_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned SVC_W     = 8;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned SRV_IDX_W = 3;
  localparam int unsigned QLEN_W    = 7;

  typedef struct packed {
    logic              arrival;
    logic [SVC_W-1:0]  service_time;
  } in_item_t;

  typedef struct packed {
    logic                 dispatched;
    logic [SRV_IDX_W-1:0] server_index;
    logic [TICK_W-1:0]    wait_time;
    logic [QLEN_W-1:0]    queue_length;
    logic                 dropped;
    logic [ACC_W-1:0]     served_total;
    logic [ACC_W-1:0]     wait_total;
    logic [ACC_W-1:0]     length_total;
    logic [ACC_W-1:0]     arrivals_total;
  } out_item_t;

endpackage

>>> hw/rtl/fmsds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read of the address written in the same cycle returns old data.
// No dependencies.
module fmsds_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/fifo_multi_server_dispatch_stats.sv
// Top level of the multi-server dispatch block with running statistics.
// Depends on fmsds_pkg and fmsds_ram.
//
// Each input item is one tick: an arrival flag and the service time to give
// a job dispatched in that tick. Each item produces exactly one result item
// with this tick's dispatch (server, wait), the queue length after the tick,
// the drop flag and four saturating 32-bit totals.
//
// Both channels use valid/stall; an item moves on a rising edge with valid
// high and stall low. The result is registered, and one item is accepted
// every cycle while in_stall_o is low. The whole tick is combinational; the
// queue head stamp is kept ready by reading the stamp RAM at the
// next head address every cycle, with a bypass for a stamp written in the
// same cycle, so the RAM's registered read port never limits the rate.
// A result register plus a skid register decouple the channels: an item is
// still taken while one result waits, and in_stall_o rises only once the
// skid register is full. Results are never lost or reordered under stall.
//
// Reset clears the tick counter, queue pointers and fill count, all servers
// to idle and all totals. The stamp RAM is not cleared; its read data is only
// used after the entry has been written.
module fifo_multi_server_dispatch_stats #(
  parameter int unsigned SERVERS     = 6,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fmsds_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fmsds_pkg::out_item_t out_data_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TICK_W = fmsds_pkg::TICK_W;
  localparam int unsigned SVC_W  = fmsds_pkg::SVC_W;
  localparam int unsigned ACC_W  = fmsds_pkg::ACC_W;
  localparam int unsigned IDX_W  = fmsds_pkg::SRV_IDX_W;
  localparam int unsigned QLEN_W = fmsds_pkg::QLEN_W;

  // State
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SVC_W-1:0]  rem_q [SERVERS];
  logic [SVC_W-1:0]  rem_d [SERVERS];
  logic [ACC_W-1:0]  served_q, served_d, wait_acc_q, wait_acc_d;
  logic [ACC_W-1:0]  length_q, length_d, arrival_q, arrival_d;
  logic              byp_q, byp_d;
  logic [TICK_W-1:0] byp_stamp_q;

  // Output staging
  logic                 out_valid_q, skid_valid_q;
  fmsds_pkg::out_item_t out_q, skid_q, result;

  // Tick evaluation
  logic              in_accept;
  logic              enq, dispatch, any_idle;
  logic [IDX_W-1:0]  sel;
  logic [SVC_W-1:0]  rem_dec [SERVERS];
  logic [FILL_W-1:0] fill_enq;
  logic [TICK_W-1:0] head_stamp, cur_stamp, wait_val;
  logic [PTR_W-1:0]  rd_addr;
  logic [TICK_W-1:0] ram_rdata;
  logic [QLEN_W+FILL_W-1:0] fill_ext;
  logic [ACC_W:0]    served_sum, wait_sum, length_sum, arrival_sum;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  assign head_stamp = byp_q ? byp_stamp_q : ram_rdata;

  always_comb begin
    enq       = in_data_i.arrival && (fill_q != FILL_W'(QUEUE_DEPTH));
    fill_enq  = fill_q + FILL_W'(enq);

    any_idle = 1'b0;
    sel      = '0;
    for (int i = 0; i < SERVERS; i++) begin
      rem_dec[i] = (rem_q[i] != '0) ? rem_q[i] - SVC_W'(1) : rem_q[i];
    end
    // Scan from the top so the lowest idle server wins
    for (int i = SERVERS - 1; i >= 0; i--) begin
      if (rem_dec[i] == '0) begin
        any_idle = 1'b1;
        sel      = IDX_W'(i);
      end
    end

    dispatch  = (fill_enq != '0) && any_idle;
    // An arrival into an empty queue is its own head
    cur_stamp = (fill_q == '0) ? tick_q : head_stamp;
    wait_val  = dispatch ? tick_q - cur_stamp : '0;

    for (int i = 0; i < SERVERS; i++) begin
      rem_d[i] = (dispatch && (sel == IDX_W'(i))) ? in_data_i.service_time : rem_dec[i];
    end

    head_d = dispatch ? ptr_next(head_q) : head_q;
    tail_d = enq ? ptr_next(tail_q) : tail_q;
    fill_d = fill_enq - FILL_W'(dispatch);
    tick_d = tick_q + TICK_W'(1);

    served_sum  = {1'b0, served_q} + (ACC_W + 1)'(dispatch);
    wait_sum    = {1'b0, wait_acc_q} + (ACC_W + 1)'(wait_val);
    length_sum  = {1'b0, length_q} + (ACC_W + 1)'(fill_d);
    arrival_sum = {1'b0, arrival_q} + (ACC_W + 1)'(enq);
    served_d    = served_sum[ACC_W]  ? '1 : served_sum[ACC_W-1:0];
    wait_acc_d  = wait_sum[ACC_W]    ? '1 : wait_sum[ACC_W-1:0];
    length_d    = length_sum[ACC_W]  ? '1 : length_sum[ACC_W-1:0];
    arrival_d   = arrival_sum[ACC_W] ? '1 : arrival_sum[ACC_W-1:0];

    // Prefetch the next head stamp; bypass when it is written this cycle
    rd_addr = in_accept ? head_d : head_q;
    byp_d   = in_accept && enq && (head_d == tail_q);

    fill_ext = {{QLEN_W{1'b0}}, fill_d};

    result.dispatched     = dispatch;
    result.server_index   = dispatch ? sel : '0;
    result.wait_time      = wait_val;
    result.queue_length   = fill_ext[QLEN_W-1:0];
    result.dropped        = in_data_i.arrival && !enq;
    result.served_total   = served_d;
    result.wait_total     = wait_acc_d;
    result.length_total   = length_d;
    result.arrivals_total = arrival_d;
  end

  fmsds_ram #(
    .WIDTH (TICK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && enq),
    .waddr_i (tail_q),
    .wdata_i (tick_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      served_q   <= '0;
      wait_acc_q <= '0;
      length_q   <= '0;
      arrival_q  <= '0;
      byp_q      <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        rem_q[i] <= '0;
      end
    end else begin
      byp_q <= byp_d;
      if (in_accept) begin
        tick_q     <= tick_d;
        head_q     <= head_d;
        tail_q     <= tail_d;
        fill_q     <= fill_d;
        served_q   <= served_d;
        wait_acc_q <= wait_acc_d;
        length_q   <= length_d;
        arrival_q  <= arrival_d;
        for (int i = 0; i < SERVERS; i++) begin
          rem_q[i] <= rem_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_stamp_q <= tick_q;
  end

  // Result register with skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q  <= skid_valid_q || in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the result register is empty");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_stalled_accept_skids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("item taken under stall was not held in the skid register");

  a_idle_result_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.dispatched) |->
      (out_data_o.server_index == '0 && out_data_o.wait_time == '0))
    else $error("result without dispatch carries a server or a wait");

endmodule
